>>> src/dssm_pkg.sv
// Package for the two-stack shared store: sizes, command and status codes,
// and the word passed from the front queue to the back end. No dependencies.
package dssm_pkg;

  localparam int DEPTH = 16;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic [2:0] CMD_PUSH_FIRST  = 3'd0;
  localparam logic [2:0] CMD_POP_FIRST   = 3'd1;
  localparam logic [2:0] CMD_PUSH_SECOND = 3'd2;
  localparam logic [2:0] CMD_POP_SECOND  = 3'd3;
  localparam logic [2:0] CMD_LIST        = 3'd4;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_LISTED = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } q_word_t;

endpackage

>>> src/dual_stack_shared_memory.sv
// Top level of the two-stack shared store: front queue plus back end.
// Depends on dssm_pkg, dssm_front and dssm_back.
//
//   channel   handshake              fields
//   command   cmd_valid / cmd_stall  command[2:0], value[31:0]
//   result    res_valid / res_stall  data[31:0], status[1:0], from_second, last
//
// A push loads the result register directly, writing the store unless it is
// full; a pop reads the store, then loads the result register. A listing
// enters its read state, then reads and emits each stored word in turn, bound
// by the single registered read port of the store. A two-entry queue decouples
// input from the back end. Reset (rst, synchronous) empties both stacks and
// the queue; no clearing pass. Either side may stall at any time.
module dual_stack_shared_memory (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] value,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] data,
  output logic [1:0]         status,
  output logic               from_second,
  output logic               last
);
  import dssm_pkg::*;

  logic    q_valid;
  q_word_t q_word;
  logic    q_take;

  dssm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .valid   (cmd_valid),
    .stall   (cmd_stall),
    .command (command),
    .value   (value),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_take  (q_take)
  );

  dssm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_take      (q_take),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .data        (data),
    .status      (status),
    .from_second (from_second),
    .last        (last)
  );
endmodule

>>> src/dssm_front.sv
// Front end: accepts command words, drops unknown codes and queues the rest.
// Depends on dssm_pkg.
module dssm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             stall,
  input  logic [2:0]       command,
  input  logic signed [31:0] value,
  output logic             q_valid,
  output dssm_pkg::q_word_t q_word,
  input  logic             q_take
);
  import dssm_pkg::*;

  q_word_t        queue [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] fill;
  logic           known;
  logic           push;
  logic           pop;

  assign known = (command == CMD_PUSH_FIRST) || (command == CMD_POP_FIRST) ||
                 (command == CMD_PUSH_SECOND) || (command == CMD_POP_SECOND) ||
                 (command == CMD_LIST);
  assign stall = (fill == QCW'(QDEPTH));
  assign push = valid && !stall && known;
  assign pop = q_take && q_valid;
  assign q_valid = (fill != '0);
  assign q_word = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{command: command, value: value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end
endmodule

>>> src/dssm_back.sv
// Back end: the shared store, both stack counts, the pop/listing sequencer
// and the result register. Depends on dssm_pkg.
module dssm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  dssm_pkg::q_word_t  q_word,
  output logic               q_take,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] data,
  output logic [1:0]         status,
  output logic               from_second,
  output logic               last
);
  import dssm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_POP   = 2'd1;
  localparam logic [1:0] ST_LREAD = 2'd2;
  localparam logic [1:0] ST_LEMIT = 2'd3;
  localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);

  logic signed [31:0] store [DEPTH];
  logic signed [31:0] rdata;
  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [CW-1:0]      count_first;
  logic [CW-1:0]      count_second;
  logic [CW-1:0]      count_first_next;
  logic [CW-1:0]      count_second_next;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      idx_next;
  logic               pop_second;
  logic               pop_second_next;
  logic [CW:0]        sum;
  logic [CW-1:0]      total;
  logic               full;
  logic               slot_free;
  logic               we;
  logic [AW-1:0]      waddr;
  logic               re;
  logic [AW-1:0]      raddr;
  logic               load;
  logic signed [31:0] load_data;
  logic [1:0]         load_status;
  logic               load_second;
  logic               load_last;
  logic [CW-1:0]      list_addr;

  assign sum = {1'b0, count_first} + {1'b0, count_second};
  assign total = sum[CW-1:0];
  assign full = (sum >= (CW + 1)'(DEPTH));
  assign slot_free = !res_valid || !res_stall;
  assign list_addr = (idx < count_first) ? idx : DEPTH_W - total + idx;

  always_comb begin
    state_next = state;
    count_first_next = count_first;
    count_second_next = count_second;
    idx_next = idx;
    pop_second_next = pop_second;
    q_take = 1'b0;
    we = 1'b0;
    waddr = '0;
    re = 1'b0;
    raddr = '0;
    load = 1'b0;
    load_data = '0;
    load_status = STAT_DONE;
    load_second = 1'b0;
    load_last = 1'b1;
    case (state)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_take = 1'b1;
          case (q_word.command)
            CMD_PUSH_FIRST: begin
              load = 1'b1;
              if (full) begin
                load_status = STAT_FULL;
              end else begin
                we = 1'b1;
                waddr = count_first[AW-1:0];
                count_first_next = count_first + 1'b1;
              end
            end
            CMD_PUSH_SECOND: begin
              load = 1'b1;
              load_second = 1'b1;
              if (full) begin
                load_status = STAT_FULL;
              end else begin
                we = 1'b1;
                waddr = AW'(DEPTH_W - 1'b1 - count_second);
                count_second_next = count_second + 1'b1;
              end
            end
            CMD_POP_FIRST: begin
              if (count_first == '0) begin
                load = 1'b1;
                load_status = STAT_EMPTY;
              end else begin
                re = 1'b1;
                raddr = AW'(count_first - 1'b1);
                count_first_next = count_first - 1'b1;
                pop_second_next = 1'b0;
                state_next = ST_POP;
              end
            end
            CMD_POP_SECOND: begin
              if (count_second == '0) begin
                load = 1'b1;
                load_status = STAT_EMPTY;
                load_second = 1'b1;
              end else begin
                re = 1'b1;
                raddr = AW'(DEPTH_W - count_second);
                count_second_next = count_second - 1'b1;
                pop_second_next = 1'b1;
                state_next = ST_POP;
              end
            end
            CMD_LIST: begin
              if (total == '0) begin
                load = 1'b1;
                load_status = STAT_EMPTY;
              end else begin
                idx_next = '0;
                state_next = ST_LREAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (slot_free) begin
          load = 1'b1;
          load_data = rdata;
          load_second = pop_second;
          state_next = ST_IDLE;
        end
      end
      ST_LREAD: begin
        re = 1'b1;
        raddr = list_addr[AW-1:0];
        state_next = ST_LEMIT;
      end
      ST_LEMIT: begin
        if (slot_free) begin
          load = 1'b1;
          load_data = rdata;
          load_status = STAT_LISTED;
          load_second = (idx >= count_first);
          load_last = ((idx + 1'b1) == total);
          if (load_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            state_next = ST_LREAD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= q_word.value;
    end
    if (re) begin
      rdata <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
      status <= load_status;
      from_second <= load_second;
      last <= load_last;
    end
    idx <= idx_next;
    pop_second <= pop_second_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count_first <= '0;
      count_second <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count_first <= count_first_next;
      count_second <= count_second_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end
endmodule
